// ===== src/cbt_pkg.sv =====
// cbt_pkg: shared constants, types and state codes for the CAN bit timing calculator
// no dependencies; used by the interfaces, the divider, the segment unit and the top level
`timescale 1ns / 1ps

package cbt_pkg;

    // field widths
    localparam int RATE_W = 20;
    localparam int BRP_W  = 7;
    localparam int TQ_W   = 5;
    localparam int SEG_W  = 4;
    localparam int BYTE_W = 8;

    // divider widths: long runs cover the full quotient, short runs the search range
    localparam int Q_W    = 22;
    localparam int SQ_W   = 11;
    localparam int CNT_W  = 5;
    localparam int STEP_W = 4;

    // half the 8 MHz oscillator, in prescaled quanta per second
    localparam logic [Q_W-1:0] OSC_HALF_HZ = Q_W'(8 * 1000 * 1000 / 2);

    localparam logic [TQ_W-1:0]   TQ_MIN       = TQ_W'(5);
    localparam logic [TQ_W-1:0]   TQ_MAX       = TQ_W'(25);
    localparam logic [BRP_W-1:0]  BRP_MAX      = BRP_W'(64);
    localparam logic [STEP_W-1:0] SEARCH_STEPS = STEP_W'(10);
    localparam logic [STEP_W-1:0] STEP_LAST    = STEP_W'(10 - 1);
    localparam logic [SEG_W-1:0]  SEG_MAX      = SEG_W'(8);
    localparam logic [SEG_W-1:0]  PS2_MIN      = SEG_W'(2);
    localparam logic [1:0]        SJW_M1       = 2'(1 - 1);

    // above this quanta count the prescaler saturates and the quanta count is 25
    localparam logic [Q_W-1:0] BRP_SAT_Q = Q_W'(64 * 25 - 25);

    // reciprocal of 25: floor(x / 25) = (x * 1311) >> 15 for any x below 2048
    localparam logic [SQ_W-1:0] BRP_RECIP    = SQ_W'(1311);
    localparam int              BRP_RECIP_SH = 15;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_QDIV,
        S_QWAIT,
        S_BRPDIV,
        S_TQDIV,
        S_TQWAIT,
        S_CDIV,
        S_CWAIT,
        S_SEG
    } cbt_state_t;

    // divider control from the sequencer
    typedef struct packed {
        logic start;
        logic short_op;
    } cbt_div_ctl_t;

    // one result word
    typedef struct packed {
        logic [BRP_W-1:0]  prescaler;
        logic [TQ_W-1:0]   quanta_per_bit;
        logic [SEG_W-1:0]  prop_segment;
        logic [SEG_W-1:0]  phase_one;
        logic [SEG_W-1:0]  phase_two;
        logic [BYTE_W-1:0] cnf1_byte;
        logic [BYTE_W-1:0] cnf2_byte;
        logic [BYTE_W-1:0] cnf3_byte;
    } cbt_res_t;

endpackage

// ===== src/cbt_chan_if.sv =====
// cbt_req_if / cbt_res_if: valid/ready channels for bitrate requests and timing results
// depends on cbt_pkg for the field widths
`timescale 1ns / 1ps

interface cbt_req_if;
    import cbt_pkg::*;

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] bitrate;

    modport source (output valid, output bitrate, input ready);
    modport sink (input valid, input bitrate, output ready);
endinterface

interface cbt_res_if;
    import cbt_pkg::*;

    logic              valid;
    logic              ready;
    logic [BRP_W-1:0]  prescaler;
    logic [TQ_W-1:0]   quanta_per_bit;
    logic [SEG_W-1:0]  prop_segment;
    logic [SEG_W-1:0]  phase_one;
    logic [SEG_W-1:0]  phase_two;
    logic [BYTE_W-1:0] cnf1_byte;
    logic [BYTE_W-1:0] cnf2_byte;
    logic [BYTE_W-1:0] cnf3_byte;

    modport source (
        output valid, output prescaler, output quanta_per_bit, output prop_segment,
        output phase_one, output phase_two, output cnf1_byte, output cnf2_byte,
        output cnf3_byte, input ready
    );
    modport sink (
        input valid, input prescaler, input quanta_per_bit, input prop_segment,
        input phase_one, input phase_two, input cnf1_byte, input cnf2_byte,
        input cnf3_byte, output ready
    );
endinterface

// ===== src/cbt_div.sv =====
// cbt_div: shared restoring divider, one quotient bit per cycle
// long runs yield a 22-bit quotient, short runs (dividend below 2048) an 11-bit one; depends on cbt_pkg
`timescale 1ns / 1ps

module cbt_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cbt_pkg::cbt_div_ctl_t        ctl,
    input  logic [cbt_pkg::Q_W-1:0]      dividend,
    input  logic [cbt_pkg::RATE_W-1:0]   divisor,
    output logic                         done,
    output logic [cbt_pkg::Q_W-1:0]      quotient
);
    import cbt_pkg::*;

    logic [Q_W-1:0]    shreg_reg, shreg_next;
    logic [RATE_W-1:0] rem_reg, rem_next;
    logic [RATE_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RATE_W:0]   trial;
    logic              take;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        shreg_next = shreg_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, shreg_reg[Q_W-1]};
        take       = (trial >= {1'b0, dvs_reg});

        if (ctl.start)
        begin
            // short runs left-align the low bits so the quotient lands in the low bits
            shreg_next = ctl.short_op ? {dividend[SQ_W-1:0], {(Q_W-SQ_W){1'b0}}} : dividend;
            rem_next   = '0;
            dvs_next   = divisor;
            cnt_next   = ctl.short_op ? CNT_W'(SQ_W) : CNT_W'(Q_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = take ? RATE_W'(trial - {1'b0, dvs_reg}) : trial[RATE_W-1:0];
            shreg_next = {shreg_reg[Q_W-2:0], take};
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        shreg_reg <= shreg_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = shreg_reg;

    // a new division only starts on an idle unit
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> !busy_reg)
        else $error("divider started while busy");

    // every run ends with a done pulse
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("divider stopped without done");

    // done lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");

endmodule

// ===== src/cbt_seg.sv =====
// cbt_seg: splits the chosen quanta count into segments and packs the three timing bytes
// combinational; depends on cbt_pkg
`timescale 1ns / 1ps

module cbt_seg (
    input  logic [cbt_pkg::BRP_W-1:0] brp,
    input  logic [cbt_pkg::TQ_W-1:0]  tq,
    output cbt_pkg::cbt_res_t         res
);
    import cbt_pkg::*;

    logic [TQ_W-1:0]  ps2_raw;
    logic [SEG_W-1:0] ps2;
    logic [TQ_W-1:0]  ps1_raw;
    logic [SEG_W-1:0] ps1;
    logic [TQ_W-1:0]  sum;
    logic [TQ_W-1:0]  prop_raw;
    logic [SEG_W-1:0] prop;
    logic [BRP_W-1:0] brp_m1;
    logic [SEG_W-1:0] ps1_m1;
    logic [SEG_W-1:0] ps2_m1;
    logic [SEG_W-1:0] prop_m1;

    always_comb
    begin
        // phase 2 gets half the bit after sync, clamped to 2..8
        ps2_raw = TQ_W'(tq - TQ_W'(1)) >> 1;
        if (ps2_raw < TQ_W'(PS2_MIN))
            ps2 = PS2_MIN;
        else if (ps2_raw > TQ_W'(SEG_MAX))
            ps2 = SEG_MAX;
        else
            ps2 = ps2_raw[SEG_W-1:0];

        // phase 1 gets half of the rest, clamped to 1..8
        ps1_raw = TQ_W'(tq - TQ_W'(ps2)) >> 1;
        if (ps1_raw < TQ_W'(1))
            ps1 = SEG_W'(1);
        else if (ps1_raw > TQ_W'(SEG_MAX))
            ps1 = SEG_MAX;
        else
            ps1 = ps1_raw[SEG_W-1:0];

        // propagation takes what is left, at least one quantum
        sum      = TQ_W'(1) + TQ_W'(ps1) + TQ_W'(ps2);
        prop_raw = (tq > sum) ? TQ_W'(tq - sum) : TQ_W'(1);
        prop     = (prop_raw > TQ_W'(SEG_MAX)) ? SEG_MAX : prop_raw[SEG_W-1:0];

        // register fields hold value minus one
        brp_m1  = brp - BRP_W'(1);
        ps1_m1  = ps1 - SEG_W'(1);
        ps2_m1  = ps2 - SEG_W'(1);
        prop_m1 = prop - SEG_W'(1);

        res.prescaler      = brp;
        res.quanta_per_bit = tq;
        res.prop_segment   = prop;
        res.phase_one      = ps1;
        res.phase_two      = ps2;
        res.cnf1_byte      = {SJW_M1, brp_m1[5:0]};
        res.cnf2_byte      = {2'b11, ps1_m1[2:0], prop_m1[2:0]};
        res.cnf3_byte      = {5'b00000, ps2_m1[2:0]};
    end

endmodule

// ===== src/can_bit_timing_calc_unit.sv =====
// can_bit_timing_calc_unit: turns a requested CAN bitrate into bit timing for an 8 MHz clock
// depends on cbt_pkg, cbt_req_if / cbt_res_if, cbt_div and cbt_seg
//
// usage
//   req channel carries one word, the requested bitrate in bits per second (0 acts as 1).
//   res channel returns one word per request: prescaler, quanta per bit, the three
//   segment lengths and the three controller timing bytes (SJW fixed at 1).
//   a word is taken when valid and ready are high at a rising edge of clk.
// sequencing
//   one request is worked at a time; req.ready is high only while the sequencer idles.
//   divisions by a variable go through one restoring divider, one quotient bit per cycle:
//   first the quanta count, then the base prescaler (not divided but a reciprocal multiply
//   by 1/25), then the base quanta count and each of up to nine search candidates in turn.
//   when the prescaler saturates, the base prescaler, base quanta count and search are
//   skipped and the saturated pair goes straight to packing.
// reset and stalls
//   rst_n clears the sequencer and the result valid flag; no pass over storage is needed.
//   the result sits in an output register until taken, and a new request is accepted
//   meanwhile; a finished result waits in the last step if the previous one is still held.
`timescale 1ns / 1ps

module can_bit_timing_calc_unit (
    input  logic       clk,
    input  logic       rst_n,
    cbt_req_if.sink    req,
    cbt_res_if.source  res
);
    import cbt_pkg::*;

    cbt_state_t        state_reg, state_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [BRP_W-1:0]  brp_reg, brp_next;
    logic [BRP_W-1:0]  cb_reg, cb_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [BRP_W-1:0]  best_brp_reg, best_brp_next;
    logic [TQ_W-1:0]   best_tq_reg, best_tq_next;
    logic [SQ_W-1:0]   diff_reg, diff_next;
    cbt_res_t          res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    cbt_div_ctl_t      div_ctl;
    logic [Q_W-1:0]    div_dividend;
    logic [RATE_W-1:0] div_divisor;
    logic              div_done;
    logic [Q_W-1:0]    div_quot;

    cbt_res_t          seg_res;

    logic [Q_W-1:0]    q_calc;
    logic [SQ_W-1:0]   ct;
    logic [TQ_W-1:0]   tq_c;
    logic [11:0]       prod_a;
    logic [SQ_W-1:0]   diff_a;
    logic [17:0]       prod_c;
    logic [SQ_W-1:0]   cd;
    logic [SQ_W-1:0]   diff_min;
    logic [SQ_W-1:0]   brp_sum;
    logic [Q_W-1:0]    brp_prod;
    logic              res_free;

    // shared divider
    cbt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // segment split and byte packing of the chosen pair
    cbt_seg u_seg (
        .brp (best_brp_reg),
        .tq  (best_tq_reg),
        .res (seg_res)
    );

    assign res_free = !res_valid_reg || res.ready;

    // quotient decoding and the small products of the search
    always_comb
    begin
        q_calc = (div_quot == '0) ? Q_W'(1) : div_quot;
        ct     = div_quot[SQ_W-1:0] + SQ_W'(1);
        if (ct < SQ_W'(TQ_MIN))
            tq_c = TQ_MIN;
        else if (ct > SQ_W'(TQ_MAX))
            tq_c = TQ_MAX;
        else
            tq_c = ct[TQ_W-1:0];
        prod_a   = 12'(tq_c) * 12'(brp_reg);
        diff_a   = SQ_W'(prod_a - 12'(q_reg[SQ_W-1:0]));
        prod_c   = 18'(cb_reg) * 18'(ct);
        cd       = SQ_W'(prod_c - 18'(q_reg[SQ_W-1:0]));
        diff_min = (cd < diff_reg) ? cd : diff_reg;
        // base prescaler (q + 24) / 25, q is below 1576 on this path
        brp_sum  = q_reg[SQ_W-1:0] + SQ_W'(TQ_MAX - TQ_W'(1));
        brp_prod = Q_W'(brp_sum) * Q_W'(BRP_RECIP);
    end

    // sequencer: next state, divider commands and register updates
    always_comb
    begin
        state_next     = state_reg;
        rate_next      = rate_reg;
        q_next         = q_reg;
        brp_next       = brp_reg;
        cb_next        = cb_reg;
        step_next      = step_reg;
        best_brp_next  = best_brp_reg;
        best_tq_next   = best_tq_reg;
        diff_next      = diff_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        div_ctl        = '0;
        div_dividend   = q_reg - Q_W'(1);
        div_divisor    = RATE_W'(cb_reg);
        req.ready      = 1'b0;

        if (res_valid_reg && res.ready)
            res_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    rate_next  = (req.bitrate == '0) ? RATE_W'(1) : req.bitrate;
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                div_ctl.start = 1'b1;
                div_dividend  = OSC_HALF_HZ;
                div_divisor   = rate_reg;
                state_next    = S_QWAIT;
            end
            S_QWAIT:
            begin
                if (div_done)
                begin
                    q_next = q_calc;
                    if (q_calc > BRP_SAT_Q)
                    begin
                        // prescaler saturates, quanta count saturates, no search
                        best_brp_next = BRP_MAX;
                        best_tq_next  = TQ_MAX;
                        state_next    = S_SEG;
                    end
                    else
                    begin
                        state_next = S_BRPDIV;
                    end
                end
            end
            S_BRPDIV:
            begin
                // base prescaler, rounded up, by reciprocal multiply
                brp_next   = brp_prod[BRP_RECIP_SH +: BRP_W];
                state_next = S_TQDIV;
            end
            S_TQDIV:
            begin
                div_ctl.start    = 1'b1;
                div_ctl.short_op = 1'b1;
                div_divisor      = RATE_W'(brp_reg);
                state_next       = S_TQWAIT;
            end
            S_TQWAIT:
            begin
                if (div_done)
                begin
                    best_brp_next = brp_reg;
                    best_tq_next  = tq_c;
                    diff_next     = diff_a;
                    step_next     = STEP_W'(1);
                    cb_next       = brp_reg + BRP_W'(1);
                    if (brp_reg < BRP_MAX && diff_a != '0)
                        state_next = S_CDIV;
                    else
                        state_next = S_SEG;
                end
            end
            S_CDIV:
            begin
                if (cb_reg > BRP_MAX)
                begin
                    state_next = S_SEG;
                end
                else
                begin
                    div_ctl.start    = 1'b1;
                    div_ctl.short_op = 1'b1;
                    state_next       = S_CWAIT;
                end
            end
            S_CWAIT:
            begin
                if (div_done)
                begin
                    if (ct < SQ_W'(TQ_MIN))
                    begin
                        // candidate would need too few quanta
                        state_next = S_SEG;
                    end
                    else
                    begin
                        if (cd < diff_reg)
                        begin
                            best_brp_next = cb_reg;
                            best_tq_next  = ct[TQ_W-1:0];
                        end
                        diff_next = diff_min;
                        if (diff_min == '0 || step_reg == STEP_LAST)
                        begin
                            state_next = S_SEG;
                        end
                        else
                        begin
                            step_next  = step_reg + STEP_W'(1);
                            cb_next    = cb_reg + BRP_W'(1);
                            state_next = S_CDIV;
                        end
                    end
                end
            end
            S_SEG:
            begin
                if (res_free)
                begin
                    res_next       = seg_res;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rate_reg     <= rate_next;
        q_reg        <= q_next;
        brp_reg      <= brp_next;
        cb_reg       <= cb_next;
        step_reg     <= step_next;
        best_brp_reg <= best_brp_next;
        best_tq_reg  <= best_tq_next;
        diff_reg     <= diff_next;
        res_reg      <= res_next;
    end

    // result word
    assign res.valid          = res_valid_reg;
    assign res.prescaler      = res_reg.prescaler;
    assign res.quanta_per_bit = res_reg.quanta_per_bit;
    assign res.prop_segment   = res_reg.prop_segment;
    assign res.phase_one      = res_reg.phase_one;
    assign res.phase_two      = res_reg.phase_two;
    assign res.cnf1_byte      = res_reg.cnf1_byte;
    assign res.cnf2_byte      = res_reg.cnf2_byte;
    assign res.cnf3_byte      = res_reg.cnf3_byte;

    // a finished word with a free output register is posted next cycle
    a_seg_posts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEG && !res_valid_reg) |=> (res_valid_reg && state_reg == S_IDLE))
        else $error("finished word not posted");

    // search step stays within the candidate window
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CWAIT) |-> (step_reg >= STEP_W'(1) && step_reg < SEARCH_STEPS))
        else $error("search step out of range");

    // the chosen quanta count is in range when the word is packed
    a_tq_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEG) |-> (best_tq_reg >= TQ_MIN && best_tq_reg <= TQ_MAX))
        else $error("quanta count out of range");

endmodule

// ===== bench/cbt_timing_checker.sv =====
// cbt_timing_checker: watches the request and result channels, predicts the bit timing word
// for every accepted bitrate and compares each returned word field by field
// depends on cbt_pkg and the cbt_req_if / cbt_res_if channel interfaces
`timescale 1ns / 1ps

module cbt_timing_checker (
    input  logic clk,
    input  logic rst_n,
    cbt_req_if   req,
    cbt_res_if   res,
    output int   fail_count,
    output int   outstanding
);
    import cbt_pkg::*;

    // expected timing words, oldest first
    cbt_res_t timing_q[$];

    function automatic int unsigned bound(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // prescaler search and segment split for one requested bitrate
    function automatic cbt_res_t calc_bit_timing(input logic [RATE_W-1:0] rate_bits);
        int unsigned rate;
        int unsigned quanta;
        int unsigned base_brp;
        int unsigned base_tq;
        int unsigned brp_pick;
        int unsigned tq_pick;
        int unsigned miss;
        int unsigned cand_brp;
        int unsigned cand_tq;
        int unsigned cand_miss;
        int unsigned ps1;
        int unsigned ps2;
        int unsigned prop;
        cbt_res_t    word;

        rate = 32'(rate_bits);
        if (rate == 0)
        begin
            rate = 1;
        end
        quanta = int'(OSC_HALF_HZ) / rate;
        if (quanta == 0)
        begin
            quanta = 1;
        end

        // base pair: smallest prescaler that fits within the quanta range
        base_brp = bound((quanta + int'(TQ_MAX) - 1) / int'(TQ_MAX), 1, int'(BRP_MAX));
        base_tq  = bound((quanta - 1) / base_brp + 1, int'(TQ_MIN), int'(TQ_MAX));
        brp_pick = base_brp;
        tq_pick  = base_tq;

        // try larger prescalers when the product misses, stop on an exact fit
        if (base_brp < int'(BRP_MAX) && base_tq * base_brp != quanta)
        begin
            miss = base_tq * base_brp - quanta;
            for (int step = 1; step < int'(SEARCH_STEPS); step++)
            begin
                cand_brp = base_brp + step;
                if (cand_brp > int'(BRP_MAX))
                begin
                    break;
                end
                cand_tq = (quanta - 1) / cand_brp + 1;
                if (cand_tq < int'(TQ_MIN))
                begin
                    break;
                end
                cand_miss = cand_brp * cand_tq - quanta;
                if (cand_miss < miss)
                begin
                    brp_pick = cand_brp;
                    tq_pick  = cand_tq;
                    miss     = cand_miss;
                end
                if (miss == 0)
                begin
                    break;
                end
            end
        end

        // segment split with clamps, sync segment is one quantum
        ps2  = bound((tq_pick - 1) / 2, int'(PS2_MIN), int'(SEG_MAX));
        ps1  = bound((tq_pick - ps2) / 2, 1, int'(SEG_MAX));
        prop = (tq_pick > 1 + ps1 + ps2) ? tq_pick - (1 + ps1 + ps2) : 1;
        prop = bound(prop, 1, int'(SEG_MAX));

        word.prescaler      = BRP_W'(brp_pick);
        word.quanta_per_bit = TQ_W'(tq_pick);
        word.prop_segment   = SEG_W'(prop);
        word.phase_one      = SEG_W'(ps1);
        word.phase_two      = SEG_W'(ps2);
        word.cnf1_byte      = {SJW_M1, 6'(brp_pick - 1)};
        word.cnf2_byte      = {2'b11, 3'(ps1 - 1), 3'(prop - 1)};
        word.cnf3_byte      = {5'b00000, 3'(ps2 - 1)};
        return word;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
        begin
            report(what, got, want);
        end
    endtask

    // score returned words, then queue a prediction for each accepted bitrate
    always @(posedge clk or negedge rst_n)
    begin
        cbt_res_t want;
        int       popped;
        int       pushed;

        if (!rst_n)
        begin
            timing_q.delete();
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            popped = 0;
            pushed = 0;
            if (res.valid && res.ready)
            begin
                if (timing_q.size() == 0)
                begin
                    report("unexpected result word, prescaler", int'(res.prescaler), 0);
                end
                else
                begin
                    want   = timing_q.pop_front();
                    popped = 1;
                    check_field("prescaler", int'(res.prescaler), int'(want.prescaler));
                    check_field("quanta_per_bit", int'(res.quanta_per_bit),
                                int'(want.quanta_per_bit));
                    check_field("prop_segment", int'(res.prop_segment),
                                int'(want.prop_segment));
                    check_field("phase_one", int'(res.phase_one), int'(want.phase_one));
                    check_field("phase_two", int'(res.phase_two), int'(want.phase_two));
                    check_field("cnf1_byte", int'(res.cnf1_byte), int'(want.cnf1_byte));
                    check_field("cnf2_byte", int'(res.cnf2_byte), int'(want.cnf2_byte));
                    check_field("cnf3_byte", int'(res.cnf3_byte), int'(want.cnf3_byte));
                end
            end
            if (req.valid && req.ready)
            begin
                timing_q.push_back(calc_bit_timing(req.bitrate));
                pushed = 1;
            end
            outstanding <= outstanding + pushed - popped;
        end
    end

    // words still owed at the end of the run
    function automatic int leftover();
        return timing_q.size();
    endfunction

endmodule

// ===== bench/testbench.sv =====
// testbench: drives bitrate requests into can_bit_timing_calc_unit with random gaps and stalls
// depends on cbt_pkg, the channel interfaces, the block itself and cbt_timing_checker
`timescale 1ns / 1ps

module testbench;
    import cbt_pkg::*;

    localparam int RANDOM_WORDS = 1850;
    localparam int CYCLE_LIMIT  = 1200000;

    logic clk;
    logic rst_n;
    logic steady;
    int   fail_count;
    int   outstanding;
    int   cycles = 0;

    cbt_req_if req_ch();
    cbt_res_if res_ch();

    can_bit_timing_calc_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    cbt_timing_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .res         (res_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result side stalls, none during the steady stretch
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= steady || ($urandom_range(0, 99) >= 28);
        end
    end

    // mostly legal bitrates, some full range noise, common rates and divider edges
    function automatic logic [RATE_W-1:0] pick_bitrate();
        int unsigned can_rates[14] = '{5000, 10000, 15000, 20000, 33333, 40000, 50000,
                                       83333, 100000, 125000, 250000, 500000, 800000,
                                       1000000};
        int unsigned sel;
        int unsigned quanta;

        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            return RATE_W'($urandom_range(5000, 1000000));
        end
        else if (sel < 65)
        begin
            return RATE_W'($urandom_range(0, (1 << RATE_W) - 1));
        end
        else if (sel < 80)
        begin
            return RATE_W'(can_rates[$urandom_range(0, 13)]);
        end
        else if (sel < 92)
        begin
            quanta = $urandom_range(4, 1700);
            return RATE_W'(int'(OSC_HALF_HZ) / quanta + $urandom_range(0, 2));
        end
        return RATE_W'($urandom_range(0, 3000));
    endfunction

    // offer one word, holding valid until it is taken
    task automatic send_rate(input logic [RATE_W-1:0] rate);
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.bitrate <= RATE_W'($urandom());
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.bitrate <= rate;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // hold off the sender until every owed word has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        logic [RATE_W-1:0] directed[$];

        // zero, tiny and saturating rates, exact fits, search hits, search bounds, top of range
        directed = '{20'd0, 20'd1, 20'd1000, 20'd2500, 20'd2538, 20'd2539, 20'd2614,
                     20'd2580, 20'd5000, 20'd25477, 20'd33333, 20'd148148, 20'd153846,
                     20'd160000, 20'd250000, 20'd500000, 20'd666666, 20'd800000,
                     20'd800001, 20'd1000000, 20'hFFFFF, 20'h55555, 20'hAAAAA};

        steady         <= 1'b0;
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.bitrate <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_rate(directed[i]);
        end
        drain();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            steady <= (n >= 600 && n < 900);
            if (n == 1200)
            begin
                drain();
            end
            send_rate(pick_bitrate());
        end

        // let the last words come back
        steady <= 1'b0;
        drain();
        repeat (200) @(posedge clk);

        if (fail_count == 0 && checker_i.leftover() == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/cbt_pkg.sv
src/cbt_chan_if.sv
src/cbt_div.sv
src/cbt_seg.sv
src/can_bit_timing_calc_unit.sv
bench/cbt_timing_checker.sv
bench/testbench.sv
